/* sv/mkrc_pkg.sv */
// ----------------------------------------------------------------------------
// mkrc_pkg
// Shared types and constants for the multi-key record comparator.
// ----------------------------------------------------------------------------
package mkrc_pkg;

	localparam int MAX_PARTS = 8;
	localparam int PART_IDX_W = $clog2(MAX_PARTS);
	localparam int PART_CNT_W = 4;

	localparam int BYTE_W = 8;
	localparam int SIZES_W = 64;
	localparam int KINDS_W = 16;
	localparam int DESC_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	typedef logic [1:0] order_t;
	localparam order_t ORD_LESS = 2'd0;
	localparam order_t ORD_EQUAL = 2'd1;
	localparam order_t ORD_GREATER = 2'd2;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_SIGNED = 2'd0;
	localparam kind_t KIND_UNSIGNED = 2'd1;
	localparam kind_t KIND_FLOAT = 2'd2;
	localparam kind_t KIND_STRING = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_PART_COUNT = 2'd0;
	localparam cfg_idx_t REG_PART_SIZES = 2'd1;
	localparam cfg_idx_t REG_PART_KINDS = 2'd2;
	localparam cfg_idx_t REG_PART_DESC = 2'd3;

	function automatic order_t cmp_bytes(input logic [BYTE_W-1:0] x,
			input logic [BYTE_W-1:0] y);
		order_t r;
		if (x > y) begin
			r = ORD_GREATER;
		end else if (x < y) begin
			r = ORD_LESS;
		end else begin
			r = ORD_EQUAL;
		end
		return r;
	endfunction

endpackage

/* sv/mkrc_item_if.sv */
// ----------------------------------------------------------------------------
// mkrc_item_if
// Byte pair channel: one byte of each record per request.
// ----------------------------------------------------------------------------
interface mkrc_item_if;
	logic valid;
	logic ready;
	logic [mkrc_pkg::BYTE_W-1:0] byte_a;
	logic [mkrc_pkg::BYTE_W-1:0] byte_b;
	logic last_byte;

	modport source (output valid, output byte_a, output byte_b, output last_byte,
		input ready);
	modport sink (input valid, input byte_a, input byte_b, input last_byte,
		output ready);
endinterface

/* sv/mkrc_result_if.sv */
// ----------------------------------------------------------------------------
// mkrc_result_if
// Result channel: one order code per record pair.
// ----------------------------------------------------------------------------
interface mkrc_result_if;
	logic valid;
	logic ready;
	mkrc_pkg::order_t order;

	modport source (output valid, output order, input ready);
	modport sink (input valid, input order, output ready);
endinterface

/* sv/mkrc_cfg_if.sv */
// ----------------------------------------------------------------------------
// mkrc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mkrc_cfg_if;
	logic valid;
	logic ready;
	mkrc_pkg::cfg_idx_t index;
	logic [mkrc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/multi_key_record_compare.sv */
// ----------------------------------------------------------------------------
// multi_key_record_compare
// Lexicographic comparator of two packed records split into key parts.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : register writes (part count, sizes, kinds, descending mask),
//            always ready; write only while no record pair is in flight.
//   item   : one byte pair per request, in record order; last_byte marks
//            the final pair of a record.
//   result : one order code (less, equal, greater) per record pair, sent
//            for the request that carries last_byte.
// Each byte pair updates the running comparison state in one step, and a
// new pair is taken every cycle unless a result is stalled. The order
// appears on the result channel in the cycle after the last pair is taken.
// The single output register lets a pair be taken while a result waits,
// as long as the receiver takes it in the same cycle; while a result is
// stalled, item ready stays low.
// Reset clears the configuration registers to zero parts (every comparison equal) and
// the running state to its start values; the block is ready at once.
// ----------------------------------------------------------------------------
module multi_key_record_compare (
	input logic clk,
	input logic arst_n,
	mkrc_cfg_if.sink cfg,
	mkrc_item_if.sink item,
	mkrc_result_if.source result
);
	import mkrc_pkg::*;

	logic [PART_CNT_W-1:0] part_count_q;
	logic [SIZES_W-1:0] part_sizes_q;
	logic [KINDS_W-1:0] part_kinds_q;
	logic [DESC_W-1:0] part_desc_q;

	logic [PART_CNT_W-1:0] part_index_q;
	logic [BYTE_W-1:0] byte_in_part_q;
	order_t part_order_q;
	logic string_ended_q;
	order_t decided_order_q;
	logic decided_q;

	logic out_valid_q;
	order_t order_q;

	logic accept;
	logic [PART_CNT_W-1:0] cnt;
	logic found;
	logic [PART_IDX_W-1:0] p;
	logic [BYTE_W-1:0] sz;
	kind_t kind;
	logic [BYTE_W-1:0] bip_inc;
	logic complete;
	logic [BYTE_W-1:0] ca;
	logic [BYTE_W-1:0] cb;
	logic size_ok;
	logic [PART_CNT_W-1:0] part_index_n;
	logic [BYTE_W-1:0] byte_in_part_n;
	order_t part_order_n;
	logic string_ended_n;
	order_t decided_order_n;
	logic decided_n;
	order_t final_order;

	assign cfg.ready = 1'b1;
	assign item.ready = !out_valid_q || result.ready;
	assign accept = item.valid && item.ready;
	assign result.valid = out_valid_q;
	assign result.order = order_q;

	// first nonempty part at or after the current index
	always_comb begin
		cnt = (part_count_q > PART_CNT_W'(MAX_PARTS)) ? PART_CNT_W'(MAX_PARTS)
			: part_count_q;
		found = 1'b0;
		p = '0;
		for (int k = MAX_PARTS - 1; k >= 0; k--) begin
			if ((PART_CNT_W'(k) >= part_index_q) && (PART_CNT_W'(k) < cnt)
					&& (part_sizes_q[k*BYTE_W +: BYTE_W] != '0)) begin
				found = 1'b1;
				p = PART_IDX_W'(k);
			end
		end
	end

	always_comb begin
		sz = part_sizes_q[p*BYTE_W +: BYTE_W];
		kind = kind_t'(part_kinds_q[p*2 +: 2]);
		bip_inc = byte_in_part_q + BYTE_W'(1);
		complete = found && (bip_inc == sz);
		size_ok = (sz == BYTE_W'(1)) || (sz == BYTE_W'(2)) || (sz == BYTE_W'(4))
			|| (sz == BYTE_W'(8));
		ca = item.byte_a;
		cb = item.byte_b;
		if ((kind == KIND_SIGNED) && complete) begin
			ca = item.byte_a ^ 8'h80;
			cb = item.byte_b ^ 8'h80;
		end

		part_index_n = part_index_q;
		byte_in_part_n = byte_in_part_q;
		part_order_n = part_order_q;
		string_ended_n = string_ended_q;
		decided_order_n = decided_order_q;
		decided_n = decided_q;

		if (found) begin
			part_index_n = {1'b0, p};
			unique case (kind)
				KIND_STRING: begin
					if (!string_ended_q && (part_order_q == ORD_EQUAL)) begin
						if (item.byte_a != item.byte_b) begin
							part_order_n = cmp_bytes(item.byte_a, item.byte_b);
						end else if (item.byte_a == '0) begin
							string_ended_n = 1'b1;
						end
					end
				end
				KIND_SIGNED, KIND_UNSIGNED: begin
					if (ca != cb) begin
						part_order_n = cmp_bytes(ca, cb);
					end
				end
				KIND_FLOAT: begin
				end
				default: begin
				end
			endcase
			byte_in_part_n = bip_inc;
			if (complete) begin
				if (((kind == KIND_STRING) || ((kind != KIND_FLOAT) && size_ok))
						&& !decided_q && (part_order_n != ORD_EQUAL)) begin
					decided_n = 1'b1;
					decided_order_n = part_desc_q[p]
						? order_t'(ORD_GREATER - part_order_n) : part_order_n;
				end
				part_index_n = PART_CNT_W'(p) + PART_CNT_W'(1);
				byte_in_part_n = '0;
				part_order_n = ORD_EQUAL;
				string_ended_n = 1'b0;
			end
		end

		final_order = decided_n ? decided_order_n : ORD_EQUAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_count_q <= '0;
			part_sizes_q <= '0;
			part_kinds_q <= '0;
			part_desc_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PART_COUNT: part_count_q <= cfg.data[PART_CNT_W-1:0];
				REG_PART_SIZES: part_sizes_q <= cfg.data[SIZES_W-1:0];
				REG_PART_KINDS: part_kinds_q <= cfg.data[KINDS_W-1:0];
				REG_PART_DESC: part_desc_q <= cfg.data[DESC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_index_q <= '0;
			byte_in_part_q <= '0;
			part_order_q <= ORD_EQUAL;
			string_ended_q <= 1'b0;
			decided_order_q <= ORD_EQUAL;
			decided_q <= 1'b0;
		end else if (accept) begin
			if (item.last_byte) begin
				part_index_q <= '0;
				byte_in_part_q <= '0;
				part_order_q <= ORD_EQUAL;
				string_ended_q <= 1'b0;
				decided_order_q <= ORD_EQUAL;
				decided_q <= 1'b0;
			end else begin
				part_index_q <= part_index_n;
				byte_in_part_q <= byte_in_part_n;
				part_order_q <= part_order_n;
				string_ended_q <= string_ended_n;
				decided_order_q <= decided_order_n;
				decided_q <= decided_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && item.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.last_byte) begin
			order_q <= final_order;
		end
	end

endmodule
